// ===== rtl/hex_byte_string_parser_assert.svh =====
// Assertion macros for the hex byte string parser.
// Used by hbsp_queue and hbsp_back; no other dependencies.
`ifndef HEX_BYTE_STRING_PARSER_ASSERT_SVH
`define HEX_BYTE_STRING_PARSER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define HBSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbsp assertion failed");

// Next-cycle implication, disabled during reset.
`define HBSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbsp assertion failed");

`else

`define HBSP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HBSP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/hbsp_pkg.sv =====
// Shared types and constants of the hex byte string parser.
// No dependencies; imported by every module of the block.
package hbsp_pkg;

  localparam int MAX_BYTES = 16;
  localparam int CFG_W     = 5;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int POS_W     = 4;
  localparam int CHAR_W    = 8;
  localparam int BYTE_W    = 8;
  localparam int NIB_W     = 4;

  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_W-1:0]  BYTE_COUNT_RESET = 5'd6;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  // One queue entry: the results caused by one accepted character.
  typedef struct packed {
    logic              has_byte;
    logic              has_status;
    logic [BYTE_W-1:0] byte_value;
    logic [POS_W-1:0]  byte_position;
    logic              status;
  } job_t;

endpackage

// ===== rtl/hbsp_front.sv =====
// Front end: accepts characters, classifies them and runs the parse state.
// Depends on hbsp_pkg; pushes result jobs into hbsp_queue.
module hbsp_front
  import hbsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [CHAR_W-1:0] in_char,
  output logic              in_ready,
  input  logic [CFG_W-1:0]  byte_count,
  input  logic              q_full,
  output logic              push,
  output job_t              push_job
);

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;
  localparam logic [1:0] PH_SEP   = 2'd3;

  logic [1:0]       phase_r, phase_nxt;
  logic [NIB_W-1:0] hi_r, hi_nxt;
  logic [NIB_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic             err_r, err_nxt;

  logic             accept;
  logic             is_nul, is_sep, is_dec, is_lhex, is_uhex, is_digit;
  logic [NIB_W-1:0] nib;
  logic [CNT_W-1:0] eff_count;
  logic             held;
  logic [BYTE_W-1:0] group;
  logic             nul_byte;
  logic [CNT_W-1:0] seen_plus;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign is_nul   = (in_char == CH_NUL);
  assign is_sep   = (in_char == CH_COLON) || (in_char == CH_DOT);
  assign is_dec   = (in_char >= CH_0)  && (in_char <= CH_9);
  assign is_lhex  = (in_char >= CH_LA) && (in_char <= CH_LF);
  assign is_uhex  = (in_char >= CH_UA) && (in_char <= CH_UF);
  assign is_digit = is_dec || is_lhex || is_uhex;
  // Letters a-f / A-F have 1..6 in the low nibble.
  assign nib      = is_dec ? in_char[NIB_W-1:0] : in_char[NIB_W-1:0] + 4'd9;

  assign eff_count = (byte_count > CNT_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : byte_count;
  assign held      = (phase_r == PH_ONE) || (phase_r == PH_TWO);
  assign group     = (phase_r == PH_TWO) ? {hi_r, lo_r} : {{(BYTE_W-NIB_W){1'b0}}, hi_r};
  assign nul_byte  = !err_r && held;
  assign seen_plus = seen_r + {{(CNT_W-1){1'b0}}, nul_byte};

  always_comb begin
    phase_nxt = phase_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    seen_nxt  = seen_r;
    err_nxt   = err_r;
    push      = 1'b0;
    push_job.has_byte      = 1'b0;
    push_job.has_status    = 1'b0;
    push_job.byte_value    = group;
    push_job.byte_position = seen_r[POS_W-1:0];
    push_job.status        = STATUS_OK;
    if (accept) begin
      if (is_nul) begin
        push                = 1'b1;
        push_job.has_byte   = nul_byte;
        push_job.has_status = 1'b1;
        push_job.status     = (err_r || seen_plus != eff_count) ? STATUS_BAD : STATUS_OK;
        phase_nxt = PH_START;
        hi_nxt    = '0;
        lo_nxt    = '0;
        seen_nxt  = '0;
        err_nxt   = 1'b0;
      end else if (!err_r) begin
        if (is_digit) begin
          case (phase_r)
            PH_START, PH_SEP: begin
              hi_nxt    = nib;
              phase_nxt = PH_ONE;
              if (seen_r >= eff_count) err_nxt = 1'b1;
            end
            PH_ONE: begin
              lo_nxt    = nib;
              phase_nxt = PH_TWO;
              if (seen_r >= eff_count) err_nxt = 1'b1;
            end
            default: err_nxt = 1'b1;
          endcase
        end else if (is_sep) begin
          if (held) begin
            push              = 1'b1;
            push_job.has_byte = 1'b1;
            seen_nxt          = seen_r + CNT_W'(1);
            phase_nxt         = PH_SEP;
          end else begin
            err_nxt = 1'b1;
          end
        end else begin
          err_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      hi_r    <= '0;
      lo_r    <= '0;
      seen_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
      seen_r  <= seen_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ===== rtl/hbsp_queue.sv =====
// Short job queue between the front end and the emitter.
// Depends on hbsp_pkg and the assertion macro header.
`include "hex_byte_string_parser_assert.svh"

module hbsp_queue
  import hbsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic head_valid,
  output logic full
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == QCNT_W'(QDEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `HBSP_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= QCNT_W'(QDEPTH))
  `HBSP_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, cnt_r != '0)
  `HBSP_ASSERT_IMP(a_push_room, clk, rst_n, push && !pop, !full)

endmodule

// ===== rtl/hbsp_back.sv =====
// Back end: turns queued jobs into result beats behind an output register.
// Depends on hbsp_pkg and the assertion macro header.
`include "hex_byte_string_parser_assert.svh"

module hbsp_back
  import hbsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  job_t              head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [BYTE_W-1:0] out_byte,
  output logic [POS_W-1:0]  out_pos,
  output logic              out_status,
  output logic              out_last
);

  logic              vld_r, vld_nxt;
  logic              byte_done_r, byte_done_nxt;
  logic              kind_r, status_r, last_r;
  logic [BYTE_W-1:0] byte_r;
  logic [POS_W-1:0]  pos_r;

  logic              load;
  logic              byte_beat;

  assign load      = !vld_r || out_ready;
  assign byte_beat = head.has_byte && !byte_done_r;
  // A byte followed by a status stays at the head until the status goes out.
  assign pop       = load && head_valid && !(byte_beat && head.has_status);

  always_comb begin
    vld_nxt       = vld_r;
    byte_done_nxt = byte_done_r;
    if (load) begin
      vld_nxt = head_valid;
      if (head_valid) byte_done_nxt = !pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      byte_done_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      byte_done_r <= byte_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (byte_beat) begin
        kind_r   <= KIND_BYTE;
        byte_r   <= head.byte_value;
        pos_r    <= head.byte_position;
        status_r <= STATUS_OK;
        last_r   <= !head.has_status;
      end else begin
        kind_r   <= KIND_STATUS;
        byte_r   <= '0;
        pos_r    <= '0;
        status_r <= head.status;
        last_r   <= 1'b1;
      end
    end
  end

  assign out_valid  = vld_r;
  assign out_kind   = kind_r;
  assign out_byte   = byte_r;
  assign out_pos    = pos_r;
  assign out_status = status_r;
  assign out_last   = last_r;

  `HBSP_ASSERT_IMP(a_split_head, clk, rst_n, byte_done_r,
                   head_valid && head.has_byte && head.has_status)
  `HBSP_ASSERT_IMP(a_status_last, clk, rst_n, vld_r && kind_r == KIND_STATUS, last_r)
  `HBSP_ASSERT_NXT(a_split_status, clk, rst_n, load && head_valid && byte_beat && head.has_status,
                   byte_done_r)

endmodule

// ===== rtl/hex_byte_string_parser.sv =====
// Hex byte string parser: accepts one character per cycle, every cycle, as long as the
// four-entry result queue has room; the per-character parse is a registered state update,
// so the input rate is bounded only by the output port. A terminating NUL that closes a
// pending group causes two results (the byte, then the status) on the output port; all
// other characters cause at most one result. A result passes through the queue entry,
// written at the accepting edge, then the output register, which loads from the queue head
// when empty or being read. byte_count (5 bits, reset 6) is written through the cfg port;
// the user must do so only while the block is idle, which the block does not enforce.
// Depends on hbsp_pkg, hbsp_front, hbsp_queue and hbsp_back.
module hex_byte_string_parser
  import hbsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CHAR_W-1:0]     in_tdata,    // [7:0] char_code
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [7:0] byte_value, [11:8] byte_position,
                                             // [12] status, [15:13] zero
  output logic                  out_tuser,   // [0] kind
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data     // [4:0] byte_count
);

  logic [CFG_W-1:0]  byte_count_r, byte_count_nxt;
  logic              q_full, push, pop, head_valid;
  job_t              push_job, head;
  logic [BYTE_W-1:0] out_byte;
  logic [POS_W-1:0]  out_pos;
  logic              out_status;

  assign cfg_ready      = 1'b1;
  assign byte_count_nxt = (cfg_valid && cfg_ready) ? cfg_data : byte_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= BYTE_COUNT_RESET;
    end else begin
      byte_count_r <= byte_count_nxt;
    end
  end

  hbsp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_char    (in_tdata),
    .in_ready   (in_tready),
    .byte_count (byte_count_r),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  hbsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  hbsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_byte   (out_byte),
    .out_pos    (out_pos),
    .out_status (out_status),
    .out_last   (out_tlast)
  );

  assign out_tdata = {{(OUT_DATA_W-BYTE_W-POS_W-1){1'b0}}, out_status, out_pos, out_byte};

endmodule

// ===== verif/tb_hex_byte_string_parser.sv =====
// Self-checking testbench for hex_byte_string_parser: feeds character strings, predicts
// the parsed bytes and end-of-string status per character, and checks every output item.
// Depends on hbsp_pkg and the RTL of the block; nothing else.
module tb_hex_byte_string_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import hbsp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 95;
  localparam int NUM_PHASES   = 9;
  localparam int LONG_HOLD    = 150;
  localparam int SETTLE       = 6;

  typedef enum logic [1:0] {PH_START, PH_ONE, PH_TWO, PH_SEP} group_phase_e;
  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_MASK, RX_SPARSE} rx_mode_e;

  typedef struct {
    logic              kind;
    logic [BYTE_W-1:0] value;
    logic [POS_W-1:0]  pos;
    logic              status;
    logic              last;
  } parse_result_t;

  // Tracks the parser state, predicts the items each character causes, matches outputs.
  class byte_parse_checker;
    logic [CFG_W-1:0]  count;
    group_phase_e      ph;
    logic [NIB_W-1:0]  hi, lo;
    logic [4:0]        seen;
    bit                err;
    parse_result_t     pending_results[$];
    int                bad_count;
    int                results_seen;
    int                strings_done;

    function new();
      count = BYTE_COUNT_RESET;
      restart();
      bad_count = 0;
      results_seen = 0;
      strings_done = 0;
    endfunction

    function void restart();
      ph = PH_START;
      hi = '0;
      lo = '0;
      seen = '0;
      err = 0;
    endfunction

    function void set_count(logic [CFG_W-1:0] v);
      count = v;
    endfunction

    function void push_result(logic kind, logic [BYTE_W-1:0] value, logic [POS_W-1:0] pos,
                              logic status, logic last);
      parse_result_t r;
      r.kind = kind;
      r.value = value;
      r.pos = pos;
      r.status = status;
      r.last = last;
      pending_results.push_back(r);
    endfunction

    function logic [BYTE_W-1:0] group_value();
      return (ph == PH_TWO) ? {hi, lo} : {4'h0, hi};
    endfunction

    function void take_char(logic [CHAR_W-1:0] ch);
      logic [4:0]       limit;
      logic [NIB_W-1:0] nib;
      bit               is_digit;
      logic             st;
      limit = (count > 5'(MAX_BYTES)) ? 5'(MAX_BYTES) : count;
      if (ch == CH_NUL) begin
        // NUL closes a pending group first, then reports the string
        if (!err && (ph == PH_ONE || ph == PH_TWO)) begin
          push_result(KIND_BYTE, group_value(), seen[POS_W-1:0], STATUS_OK, 1'b0);
          seen++;
        end
        st = (err || seen != limit) ? STATUS_BAD : STATUS_OK;
        push_result(KIND_STATUS, '0, '0, st, 1'b1);
        restart();
        strings_done++;
        return;
      end
      if (err) return;
      is_digit = 1;
      nib = '0;
      if (ch >= CH_0 && ch <= CH_9) nib = 4'(ch - CH_0);
      else if (ch >= CH_LA && ch <= CH_LF) nib = 4'(ch - CH_LA + 8'd10);
      else if (ch >= CH_UA && ch <= CH_UF) nib = 4'(ch - CH_UA + 8'd10);
      else is_digit = 0;
      if (is_digit) begin
        case (ph)
          PH_START, PH_SEP: begin
            hi = nib;
            ph = PH_ONE;
          end
          PH_ONE: begin
            lo = nib;
            ph = PH_TWO;
          end
          default: begin
            err = 1;
            return;
          end
        endcase
        // a digit past the configured group count marks the string bad
        if (seen >= limit) err = 1;
      end else if (ch == CH_COLON || ch == CH_DOT) begin
        if (ph != PH_ONE && ph != PH_TWO) begin
          err = 1;
          return;
        end
        push_result(KIND_BYTE, group_value(), seen[POS_W-1:0], STATUS_OK, 1'b1);
        seen++;
        ph = PH_SEP;
      end else begin
        err = 1;
      end
    endfunction

    function void field_ok(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
        bad_count++;
      end
    endfunction

    function void match_result(parse_result_t got);
      parse_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected item: kind %0d value %0h pos %0d status %0d last %0d",
               got.kind, got.value, got.pos, got.status, got.last);
        bad_count++;
        return;
      end
      want = pending_results.pop_front();
      field_ok("kind", want.kind, got.kind);
      field_ok("byte_value", want.value, got.value);
      field_ok("byte_position", want.pos, got.pos);
      field_ok("status", want.status, got.status);
      field_ok("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [CHAR_W-1:0]     in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;

  byte_parse_checker     sb;
  logic [CHAR_W-1:0]     char_run[$];
  int                    burst_left;
  int                    items_sent;
  int                    cycles;
  bit                    long_hold_go;

  hex_byte_string_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_hex_byte_string_parser: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    parse_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind   = out_tuser;
      got.value  = out_tdata[7:0];
      got.pos    = out_tdata[11:8];
      got.status = out_tdata[12];
      got.last   = out_tlast;
      sb.match_result(got);
    end
  end

  // Receiver: stretches of different ready patterns, plus one long hold-off on request.
  initial begin
    rx_mode_e    mode;
    int          span;
    logic [7:0]  mask;
    bit          hold_taken;
    hold_taken = 0;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      mask = 8'($urandom);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        if (long_hold_go && !hold_taken) begin
          hold_taken = 1;
          out_tready <= 1'b0;
          repeat (LONG_HOLD) @(negedge clk);
        end
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
          RX_MASK:   out_tready <= mask[i % 8];
          default:   out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_char(logic [CHAR_W-1:0] c);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    sb.take_char(c);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic send_run();
    int gap;
    foreach (char_run[i]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          @(negedge clk);
          in_tvalid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      end
      send_char(char_run[i]);
      burst_left--;
    end
  endtask

  task automatic write_count(logic [CFG_W-1:0] v);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_count(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void load_text(string s);
    for (int i = 0; i < s.len(); i++) char_run.push_back(s[i]);
    char_run.push_back(CH_NUL);
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CH_0 + 8'(v);
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(v - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] sep_char();
    return $urandom_range(0, 1) ? CH_COLON : CH_DOT;
  endfunction

  // Mostly well-formed strings of the configured group count; the rest miscounted or broken.
  function automatic void fill_run(int groups);
    int sel, n, p;
    logic [CHAR_W-1:0] extra;
    char_run.delete();
    sel = $urandom_range(0, 9);
    if (sel == 9) begin
      repeat ($urandom_range(1, 6)) char_run.push_back(8'($urandom_range(1, 255)));
      char_run.push_back(CH_NUL);
      return;
    end
    n = groups;
    if (sel == 0) n = groups + 1;
    else if (sel == 1 && groups > 0) n = groups - 1;
    for (int g = 0; g < n; g++) begin
      if (g > 0) char_run.push_back(sep_char());
      char_run.push_back(hex_char());
      if ($urandom_range(0, 1)) char_run.push_back(hex_char());
    end
    if (n > 0 && $urandom_range(0, 5) == 0) char_run.push_back(sep_char());
    if (sel >= 7) begin
      p = $urandom_range(0, char_run.size());
      case ($urandom_range(0, 3))
        0:       extra = 8'($urandom_range(0, 255));
        1:       extra = hex_char();
        default: extra = sep_char();
      endcase
      if (p < char_run.size() && $urandom_range(0, 1)) char_run[p] = extra;
      else char_run.insert(p, extra);
    end
    char_run.push_back(CH_NUL);
  endfunction

  initial begin
    logic [CFG_W-1:0] phase_counts[NUM_PHASES];
    int phase_start;
    int run_idx;
    int groups;
    sb = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    items_sent  = 0;
    cycles      = 0;
    burst_left  = 0;
    long_hold_go = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: both cases, both separators, NUL closing a group, trailing separator,
    // third digit, leading and doubled separators, empty string, high codes, extra group.
    write_count(5'd2);
    char_run.delete();
    load_text("fF:0");
    load_text("A9.a:");
    load_text("123");
    load_text(":");
    load_text("");
    char_run.push_back(8'hFF);
    char_run.push_back(CH_NUL);
    char_run.push_back(8'h80);
    char_run.push_back(CH_NUL);
    load_text("1:2:3");
    load_text("1::2");
    send_run();

    phase_counts[0] = 5'd6;
    phase_counts[1] = 5'd16;
    phase_counts[2] = 5'd1;
    phase_counts[3] = 5'd0;
    phase_counts[4] = 5'd31;
    phase_counts[5] = 5'd17;
    for (int k = 6; k < NUM_PHASES; k++) phase_counts[k] = 5'($urandom_range(0, 31));

    for (int k = 0; k < NUM_PHASES; k++) begin
      write_count(phase_counts[k]);
      groups = (phase_counts[k] > 5'(MAX_BYTES)) ? MAX_BYTES : int'(phase_counts[k]);
      // hold the receiver off while the long strings of this phase keep coming
      if (k == 1) long_hold_go = 1;
      phase_start = items_sent;
      run_idx = 0;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        fill_run(groups);
        send_run();
        if (run_idx == 0 || $urandom_range(0, 7) == 0) drain_results();
        run_idx++;
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d characters in %0d strings, %0d output items checked,",
             items_sent, sb.strings_done, sb.results_seen);
    $display("group counts from 0 to 31 with random gaps, stalls and one long hold-off");
    if (sb.bad_count == 0 && sb.pending_results.size() == 0) begin
      $display("tb_hex_byte_string_parser: PASS");
    end else begin
      $display("tb_hex_byte_string_parser: FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hbsp_pkg.sv
rtl/hbsp_front.sv
rtl/hbsp_queue.sv
rtl/hbsp_back.sv
rtl/hex_byte_string_parser.sv
verif/tb_hex_byte_string_parser.sv
